/* design/roav_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roav_pkg
// Shared types, codes and sizes of the route origin validator.
// ----------------------------------------------------------------------------
package roav_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Operation codes
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_APPEND  = 2'd1;
  localparam logic [1:0] OP_PREFIX  = 2'd2;
  localparam logic [1:0] OP_ADDRESS = 2'd3;

  // Verdict codes
  localparam logic [1:0] VERDICT_VALID     = 2'd0;
  localparam logic [1:0] VERDICT_INVALID   = 2'd1;
  localparam logic [1:0] VERDICT_NOT_FOUND = 2'd2;
  localparam logic [1:0] VERDICT_NONE      = 2'd3;

  localparam logic [7:0] IPV4_MAX_LEN = 8'd32;
  localparam logic [7:0] IPV6_MAX_LEN = 8'd128;

  // Input item packing: family, address_high, address_low, query_length,
  // entry_max_length, origin AS from the lowest bit up
  localparam int IN_FAM_BIT  = 0;
  localparam int IN_HIGH_LSB = 1;
  localparam int IN_LOW_LSB  = 65;
  localparam int IN_QLEN_LSB = 129;
  localparam int IN_QMAX_LSB = 137;
  localparam int IN_ASN_LSB  = 145;
  localparam int IN_FIELDS_W = 177;
  localparam int IN_W        = ((IN_FIELDS_W + 7) / 8) * 8;

  // Result item packing: verdict, table_full, entry_count from the lowest bit up
  localparam int OUT_VERDICT_LSB = 0;
  localparam int OUT_FULL_BIT    = 2;
  localparam int OUT_CNT_LSB     = 3;
  localparam int OUT_FIELDS_W    = 3 + CNT_W;
  localparam int OUT_W           = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [7:0]  net_len;
    logic [7:0]  max_len;
    logic        family;
    logic [31:0] origin;
  } entry_t;

  typedef struct packed {
    logic [1:0]  op;
    logic        family;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [7:0]  qlen;
    logic [7:0]  qmax;
    logic [31:0] asn;
  } query_t;

  typedef struct packed {
    logic covered;
    logic origin_eq;
  } cover_t;

endpackage

/* design/roa_origin_validator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roa_origin_validator
// Sequence: an accepted item is registered, then executed; clear and append
//   go straight to the finish state, a validation walks the held entries
//   (none on an empty table) and stops early when an AS match is found.
// Throughput: one item at a time; the walk reads one entry per cycle from
//   the single read port of the entry store.
// Reset: asynchronous, active low; empties the table (count to zero). The
//   entry store is not cleared and needs no sweep after reset.
// ----------------------------------------------------------------------------
module roa_origin_validator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // family, address_high, address_low, query_length, entry_max_length,
  // origin AS, zero fill
  input  logic [roav_pkg::IN_W-1:0] s_axis_tdata_i,
  // operation
  input  logic [1:0]                s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // verdict, table_full, entry_count, zero fill
  output logic [roav_pkg::OUT_W-1:0] m_axis_tdata_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_WALK   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  localparam int CW = roav_pkg::CNT_W;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          rd_vld_q;
  logic          covered_q, covered_d;
  logic          hit_q, hit_d;
  logic          out_valid_q, out_valid_d;
  logic [1:0]    verdict_q, verdict_d;
  logic          full_q, full_d;
  logic [roav_pkg::OUT_W-1:0] out_data_q, out_data_d;

  roav_pkg::query_t query_q;
  roav_pkg::entry_t wr_entry;
  roav_pkg::entry_t rd_entry;
  roav_pkg::cover_t cov;

  logic accept;
  logic issue;
  logic hit_now;
  logic out_free;
  logic we;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign hit_now = (state_q == ST_WALK) && rd_vld_q && !hit_q && cov.covered && cov.origin_eq;
  assign issue   = (state_q == ST_WALK) && (idx_q < count_q) && !hit_q && !hit_now;

  assign wr_entry.addr_high = query_q.addr_high;
  assign wr_entry.addr_low  = query_q.addr_low;
  assign wr_entry.net_len   = query_q.qlen;
  assign wr_entry.max_len   = query_q.qmax;
  assign wr_entry.family    = query_q.family;
  assign wr_entry.origin    = query_q.asn;

  roav_table u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[roav_pkg::IDX_W-1:0]),
    .wdata_i (wr_entry),
    .re_i    (issue),
    .raddr_i (idx_q[roav_pkg::IDX_W-1:0]),
    .rdata_o (rd_entry)
  );

  roav_cover u_cover (
    .entry_i (rd_entry),
    .query_i (query_q),
    .cover_o (cov)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    covered_d   = covered_q;
    hit_d       = hit_q;
    verdict_d   = verdict_q;
    full_d      = full_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    we          = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        full_d    = 1'b0;
        verdict_d = roav_pkg::VERDICT_NONE;
        idx_d     = '0;
        covered_d = 1'b0;
        hit_d     = 1'b0;
        case (query_q.op)
          roav_pkg::OP_CLEAR: begin
            count_d = '0;
            state_d = ST_FINISH;
          end
          roav_pkg::OP_APPEND: begin
            if (count_q < CW'(roav_pkg::TABLE_DEPTH)) begin
              we      = 1'b1;
              count_d = count_q + CW'(1);
            end else begin
              full_d = 1'b1;
            end
            state_d = ST_FINISH;
          end
          default: begin
            state_d = ST_WALK;
          end
        endcase
      end
      ST_WALK: begin
        if (issue) begin
          idx_d = idx_q + CW'(1);
        end
        if (rd_vld_q && !hit_q && cov.covered) begin
          covered_d = 1'b1;
          if (cov.origin_eq) begin
            hit_d = 1'b1;
          end
        end
        // Stop on the first AS match or once every held entry is checked
        if (hit_q || ((idx_q == count_q) && !rd_vld_q)) begin
          if (hit_q) begin
            verdict_d = roav_pkg::VERDICT_VALID;
          end else if (covered_q) begin
            verdict_d = roav_pkg::VERDICT_INVALID;
          end else begin
            verdict_d = roav_pkg::VERDICT_NOT_FOUND;
          end
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold the result until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_data_d[roav_pkg::OUT_VERDICT_LSB +: 2] = verdict_q;
          out_data_d[roav_pkg::OUT_FULL_BIT]         = full_q;
          out_data_d[roav_pkg::OUT_CNT_LSB +: CW]    = count_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      covered_q   <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      rd_vld_q    <= issue;
      covered_q   <= covered_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q  <= verdict_d;
    full_q     <= full_d;
    out_data_q <= out_data_d;
    if (accept) begin
      query_q.op        <= s_axis_tuser_i;
      query_q.family    <= s_axis_tdata_i[roav_pkg::IN_FAM_BIT];
      query_q.addr_high <= s_axis_tdata_i[roav_pkg::IN_HIGH_LSB +: 64];
      query_q.addr_low  <= s_axis_tdata_i[roav_pkg::IN_LOW_LSB +: 64];
      query_q.qlen      <= s_axis_tdata_i[roav_pkg::IN_QLEN_LSB +: 8];
      query_q.qmax      <= s_axis_tdata_i[roav_pkg::IN_QMAX_LSB +: 8];
      query_q.asn       <= s_axis_tdata_i[roav_pkg::IN_ASN_LSB +: 32];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(roav_pkg::TABLE_DEPTH))
    else $error("entry count above table depth");

  a_walk_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (idx_q <= count_q))
    else $error("walk index beyond held entries");

  a_full_only_at_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[roav_pkg::OUT_FULL_BIT]) |->
      (out_data_q[roav_pkg::OUT_CNT_LSB +: CW] == CW'(roav_pkg::TABLE_DEPTH)))
    else $error("table full reported below depth");

  a_match_needs_entries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q &&
     ((out_data_q[roav_pkg::OUT_VERDICT_LSB +: 2] == roav_pkg::VERDICT_VALID) ||
      (out_data_q[roav_pkg::OUT_VERDICT_LSB +: 2] == roav_pkg::VERDICT_INVALID))) |->
      (out_data_q[roav_pkg::OUT_CNT_LSB +: CW] != '0))
    else $error("covering verdict on an empty table");

  a_no_read_outside_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_WALK) |=> !(rd_vld_q && $past(state_q) != ST_WALK))
    else $error("entry read issued outside a walk");

endmodule

/* design/roav_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roav_table
// Authorization entry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module roav_table (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [roav_pkg::IDX_W-1:0] waddr_i,
  input  roav_pkg::entry_t      wdata_i,
  input  logic                  re_i,
  input  logic [roav_pkg::IDX_W-1:0] raddr_i,
  output roav_pkg::entry_t      rdata_o
);

  roav_pkg::entry_t mem [roav_pkg::TABLE_DEPTH];
  roav_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/roav_cover.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roav_cover
// Compare unit: decides whether one entry covers the query and carries its AS.
// ----------------------------------------------------------------------------
module roav_cover (
  input  roav_pkg::entry_t entry_i,
  input  roav_pkg::query_t query_i,
  output roav_pkg::cover_t cover_o
);

  logic [31:0]  mask4;
  logic [127:0] mask6;
  logic         net4;
  logic         net6;
  logic         net_ok;
  logic         len_ok;

  // Leading-ones masks; a length of zero gives an empty mask and matches all
  assign mask4 = ~({32{1'b1}} >> entry_i.net_len);
  assign mask6 = ~({128{1'b1}} >> entry_i.net_len);

  assign net4 = (entry_i.net_len <= roav_pkg::IPV4_MAX_LEN) &&
                (((query_i.addr_low[31:0] ^ entry_i.addr_low[31:0]) & mask4) == 32'd0);
  assign net6 = (entry_i.net_len <= roav_pkg::IPV6_MAX_LEN) &&
                ((({query_i.addr_high, query_i.addr_low} ^
                   {entry_i.addr_high, entry_i.addr_low}) & mask6) == 128'd0);

  assign net_ok = (query_i.family == entry_i.family) && (query_i.family ? net6 : net4);

  // Address mode skips the length window
  assign len_ok = (query_i.op != roav_pkg::OP_PREFIX) ||
                  ((entry_i.net_len <= query_i.qlen) && (query_i.qlen <= entry_i.max_len));

  assign cover_o.covered   = net_ok && len_ok;
  assign cover_o.origin_eq = (entry_i.origin == query_i.asn);

endmodule

/* bench/roa_verdict_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roa_verdict_checker
// Watches both stream channels of the origin validator. Keeps its own copy of
// the authorization table, works out the verdict, full flag and entry count
// for every accepted item, and compares each accepted result field by field
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module roa_verdict_checker
  import roav_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [IN_W-1:0]   in_data_i,
  input  logic [1:0]        in_op_i,
  input  logic              res_valid_i,
  input  logic              res_ready_i,
  input  logic [OUT_W-1:0]  res_data_i,
  output logic [31:0]       fail_count_o,
  output logic [31:0]       pending_o
);

  typedef struct packed {
    logic [1:0]       verdict;
    logic             full;
    logic [CNT_W-1:0] count;
  } roa_outcome_t;

  entry_t       roa_store [TABLE_DEPTH];
  int           held_count;
  roa_outcome_t awaited [$];
  int           errs = 0;

  assign fail_count_o = errs;

  task automatic report(input string what, input longint exp_val, input longint got_val);
    $display("%0t ns  mismatch: %s  expected %0d  got %0d", $realtime, what, exp_val,
             got_val);
    errs++;
  endtask

  // Network part of the covering rule: family, then leading prefix bits
  function automatic logic net_covers(logic fam, logic [63:0] hi, logic [63:0] lo, entry_t e);
    logic [127:0] mask6;
    logic [31:0]  mask4;
    if (fam != e.family) return 1'b0;
    if (e.net_len == 8'd0) return 1'b1;
    if (!fam) begin
      if (e.net_len > IPV4_MAX_LEN) return 1'b0;
      mask4 = 32'hFFFF_FFFF << (32 - e.net_len);
      return ((lo[31:0] ^ e.addr_low[31:0]) & mask4) == 32'd0;
    end
    if (e.net_len > IPV6_MAX_LEN) return 1'b0;
    mask6 = {128{1'b1}} << (128 - e.net_len);
    return (({hi, lo} ^ {e.addr_high, e.addr_low}) & mask6) == 128'd0;
  endfunction

  task automatic apply_roa_item(input logic [1:0] op, input query_t q,
                                output roa_outcome_t r);
    entry_t e;
    logic   covered;
    logic   hit;
    int     i;
    r.verdict = VERDICT_NONE;
    r.full    = 1'b0;
    covered   = 1'b0;
    hit       = 1'b0;
    case (op)
      OP_CLEAR: begin
        held_count = 0;
      end
      OP_APPEND: begin
        if (held_count >= TABLE_DEPTH) begin
          r.full = 1'b1;
        end else begin
          e.addr_high = q.addr_high;
          e.addr_low  = q.addr_low;
          e.net_len   = q.qlen;
          e.max_len   = q.qmax;
          e.family    = q.family;
          e.origin    = q.asn;
          roa_store[held_count] = e;
          held_count++;
        end
      end
      default: begin
        // walk in append order, stop at the first covering entry with our AS
        for (i = 0; i < held_count && !hit; i++) begin
          e = roa_store[i];
          if (op == OP_PREFIX && e.net_len > q.qlen) continue;
          if (!net_covers(q.family, q.addr_high, q.addr_low, e)) continue;
          if (op == OP_PREFIX && q.qlen > e.max_len) continue;
          covered = 1'b1;
          if (e.origin == q.asn) hit = 1'b1;
        end
        if (hit) r.verdict = VERDICT_VALID;
        else if (covered) r.verdict = VERDICT_INVALID;
        else r.verdict = VERDICT_NOT_FOUND;
      end
    endcase
    r.count = CNT_W'(held_count);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    query_t       q;
    roa_outcome_t want;
    roa_outcome_t got;
    if (!rst_ni) begin
      held_count = 0;
      awaited.delete();
      pending_o <= '0;
    end else begin
      // retire before predicting: a result never belongs to an item taken this edge
      if (res_valid_i && res_ready_i) begin
        got.verdict = res_data_i[OUT_VERDICT_LSB +: 2];
        got.full    = res_data_i[OUT_FULL_BIT];
        got.count   = res_data_i[OUT_CNT_LSB +: CNT_W];
        if (awaited.size() == 0) begin
          report("result item with nothing outstanding, verdict", -1, got.verdict);
        end else begin
          want = awaited.pop_front();
          if (got.verdict != want.verdict) report("verdict", want.verdict, got.verdict);
          if (got.full != want.full) report("table_full", want.full, got.full);
          if (got.count != want.count) report("entry_count", want.count, got.count);
        end
      end
      if (in_valid_i && in_ready_i) begin
        q.op        = in_op_i;
        q.family    = in_data_i[IN_FAM_BIT];
        q.addr_high = in_data_i[IN_HIGH_LSB +: 64];
        q.addr_low  = in_data_i[IN_LOW_LSB +: 64];
        q.qlen      = in_data_i[IN_QLEN_LSB +: 8];
        q.qmax      = in_data_i[IN_QMAX_LSB +: 8];
        q.asn       = in_data_i[IN_ASN_LSB +: 32];
        apply_roa_item(in_op_i, q, want);
        awaited.insert(awaited.size(), want);
      end
      pending_o <= awaited.size();
    end
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the route origin validator: a directed pass over the corner
// cases, a full-table pass, then random phases of clears, appends and
// validations built mostly from stored entries, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import roav_pkg::*;

  localparam int N_ITEMS = 1300;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid_i;
  logic              s_axis_tready_o;
  logic [IN_W-1:0]   s_axis_tdata_i;
  logic [1:0]        s_axis_tuser_i;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i;
  logic [OUT_W-1:0]  m_axis_tdata_o;
  logic [31:0]       fail_cnt;
  logic [31:0]       pending_cnt;

  entry_t roa_shadow [$];
  int     sent = 0;
  bit     calm = 1'b0;

  roa_origin_validator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  roa_verdict_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_i   (s_axis_tready_o),
    .in_data_i    (s_axis_tdata_i),
    .in_op_i      (s_axis_tuser_i),
    .res_valid_i  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_data_i   (m_axis_tdata_o),
    .fail_count_o (fail_cnt),
    .pending_o    (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #12_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(30, 200);
  endfunction

  function automatic logic [31:0] pick_asn();
    if ($urandom_range(0, 9) < 7) return 32'd64496 + $urandom_range(0, 5);
    return $urandom;
  endfunction

  // Bits of {addr_high, addr_low} that an entry of this length pins down
  function automatic logic [127:0] keep_mask(logic fam, logic [7:0] len);
    logic [127:0] m;
    m = '0;
    if (fam) begin
      if (len >= 8'd128) m = '1;
      else if (len != 8'd0) m = {128{1'b1}} << (128 - len);
    end else begin
      if (len >= 8'd32) m[31:0] = '1;
      else if (len != 8'd0) m[31:0] = 32'hFFFF_FFFF << (32 - len);
    end
    return m;
  endfunction

  function automatic query_t random_entry();
    query_t q;
    int     lim;
    q.op        = OP_APPEND;
    q.family    = 1'($urandom_range(0, 1));
    q.addr_high = {$urandom, $urandom};
    q.addr_low  = {$urandom, $urandom};
    // crowd some entries into a few networks so they overlap
    if ($urandom_range(0, 1)) begin
      q.addr_high[63:16]    = 48'h2001_0db8_0000;
      q.addr_high[15:14]    = 2'($urandom_range(0, 3));
      q.addr_low[31:24]     = 8'd10;
      q.addr_low[23:18]     = 6'd0;
    end
    lim = q.family ? 128 : 32;
    if ($urandom_range(0, 15) == 0) q.qlen = 8'($urandom);
    else if ($urandom_range(0, 7) == 0) q.qlen = 8'd0;
    else q.qlen = 8'($urandom_range(1, lim));
    if ($urandom_range(0, 9) == 0 || q.qlen > lim) q.qmax = 8'($urandom);
    else q.qmax = 8'($urandom_range(q.qlen, lim));
    q.asn = pick_asn();
    return q;
  endfunction

  function automatic query_t derived_query(entry_t e);
    query_t       q;
    logic [127:0] keep;
    logic [127:0] addr;
    int           idx;
    q.op     = $urandom_range(0, 1) ? OP_PREFIX : OP_ADDRESS;
    q.family = e.family;
    if ($urandom_range(0, 15) == 0) q.family = ~e.family;
    keep = keep_mask(e.family, e.net_len);
    addr = ({e.addr_high, e.addr_low} & keep) |
           ({$urandom, $urandom, $urandom, $urandom} & ~keep);
    // near miss: one bit off, usually inside the compared part
    if ($urandom_range(0, 9) == 0) begin
      idx = e.family ? $urandom_range(0, 127) : $urandom_range(0, 31);
      addr[idx] = ~addr[idx];
    end
    {q.addr_high, q.addr_low} = addr;
    if (e.net_len <= e.max_len && $urandom_range(0, 4) != 0)
      q.qlen = 8'($urandom_range(e.net_len, e.max_len));
    else
      q.qlen = 8'($urandom);
    q.qmax = 8'($urandom);
    q.asn  = $urandom_range(0, 1) ? e.origin : pick_asn();
    return q;
  endfunction

  task automatic send_item(input query_t q);
    int              gap;
    logic [IN_W-1:0] word;
    entry_t          e;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    word = '0;
    word[IN_FAM_BIT]          = q.family;
    word[IN_HIGH_LSB +: 64]   = q.addr_high;
    word[IN_LOW_LSB +: 64]    = q.addr_low;
    word[IN_QLEN_LSB +: 8]    = q.qlen;
    word[IN_QMAX_LSB +: 8]    = q.qmax;
    word[IN_ASN_LSB +: 32]    = q.asn;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= q.op;
    s_axis_tdata_i  <= word;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent++;
    if (q.op == OP_CLEAR) begin
      roa_shadow.delete();
    end else if (q.op == OP_APPEND && roa_shadow.size() < TABLE_DEPTH) begin
      e.addr_high = q.addr_high;
      e.addr_low  = q.addr_low;
      e.net_len   = q.qlen;
      e.max_len   = q.qmax;
      e.family    = q.family;
      e.origin    = q.asn;
      roa_shadow.insert(roa_shadow.size(), e);
    end
  endtask

  task automatic put(input logic [1:0] op, input logic fam, input logic [63:0] hi,
                     input logic [63:0] lo, input logic [7:0] qlen, input logic [7:0] qmax,
                     input logic [31:0] asn);
    query_t q;
    q.op        = op;
    q.family    = fam;
    q.addr_high = hi;
    q.addr_low  = lo;
    q.qlen      = qlen;
    q.qmax      = qmax;
    q.asn       = asn;
    send_item(q);
  endtask

  // Fill to capacity, push past it, probe the full table, then empty it
  task automatic fill_table();
    query_t q;
    q = random_entry();
    q.op = OP_CLEAR;
    send_item(q);
    while (roa_shadow.size() < TABLE_DEPTH) send_item(random_entry());
    repeat (3) send_item(random_entry());
    repeat (6) send_item(derived_query(roa_shadow[$urandom_range(0, TABLE_DEPTH - 1)]));
    send_item(q);
  endtask

  // Result side: bursts of ready broken by stalls of random length
  initial begin
    int stall;
    m_axis_tready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      m_axis_tready_i <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      stall = calm ? 0 : pick_gap();
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin
    query_t q;
    int     r;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = OP_CLEAR;
    rst_ni          = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table
    put(OP_PREFIX,  1'b0, 64'd0, 64'h0A01_0000, 8'd16, 8'd0, 32'd65000);
    put(OP_ADDRESS, 1'b1, '1, '1, 8'd0, 8'd0, 32'd0);
    // unusual entries: junk above an IPv4 address, origin zero, length zero,
    // lengths past the family limit, full-length host, max below length
    put(OP_APPEND, 1'b0, '1, 64'hDEAD_BEEF_0A00_0000, 8'd8, 8'd24, 32'd65000);
    put(OP_APPEND, 1'b1, 64'h2001_0DB8_0000_0000, 64'd0, 8'd32, 8'd48, 32'd0);
    put(OP_APPEND, 1'b0, 64'd0, 64'd0, 8'd0, 8'd32, 32'd1);
    put(OP_APPEND, 1'b0, 64'd0, 64'h0A00_0000, 8'd40, 8'd255, 32'd65000);
    put(OP_APPEND, 1'b1, '1, '1, 8'd129, 8'd255, 32'd7);
    put(OP_APPEND, 1'b1, '1, '1, 8'd128, 8'd128, 32'hFFFF_FFFF);
    put(OP_APPEND, 1'b0, 64'd0, 64'hC0A8_0000, 8'd24, 8'd16, 32'd64512);
    put(OP_PREFIX,  1'b0, 64'd0, 64'h0A01_0000, 8'd16, 8'd0, 32'd65000);
    put(OP_PREFIX,  1'b0, 64'd0, 64'h0A01_0000, 8'd16, 8'd0, 32'd65001);
    put(OP_PREFIX,  1'b0, 64'd0, 64'h0A01_0000, 8'd16, 8'd0, 32'd1);
    put(OP_ADDRESS, 1'b0, 64'd0, 64'h0A0A_0A0A, 8'd255, 8'd255, 32'd65000);
    put(OP_PREFIX,  1'b0, 64'd0, 64'h0A00_0000, 8'd255, 8'd0, 32'd65000);
    put(OP_PREFIX,  1'b1, 64'h2001_0DB8_1234_0000, 64'd0, 8'd40, 8'd0, 32'd0);
    put(OP_PREFIX,  1'b1, '1, '1, 8'd128, 8'd0, 32'hFFFF_FFFF);
    put(OP_ADDRESS, 1'b1, '1, 64'hFFFF_FFFF_FFFF_FFFE, 8'd0, 8'd0, 32'hFFFF_FFFF);
    put(OP_PREFIX,  1'b0, 64'd0, 64'hC0A8_0001, 8'd20, 8'd0, 32'd64512);
    put(OP_ADDRESS, 1'b0, 64'd0, 64'hC0A8_00FF, 8'd0, 8'd0, 32'd64512);
    // clear leaves contents behind but nothing may be found
    put(OP_CLEAR,   1'b1, '1, '1, 8'd255, 8'd255, '1);
    put(OP_ADDRESS, 1'b0, 64'd0, 64'd0, 8'd0, 8'd0, 32'd1);
    put(OP_APPEND,  1'b0, 64'd0, 64'd0, 8'd0, 8'd0, 32'd0);
    put(OP_PREFIX,  1'b0, 64'd0, 64'h1234_5678, 8'd0, 8'd0, 32'd0);

    fill_table();

    while (sent < N_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 39) == 0) fill_table();
      if (roa_shadow.size() > 40 || $urandom_range(0, 2) == 0) begin
        q = random_entry();
        q.op = OP_CLEAR;
        send_item(q);
      end
      repeat ($urandom_range(1, 10)) send_item(random_entry());
      repeat ($urandom_range(6, 24)) begin
        r = $urandom_range(0, 19);
        if (r < 2) begin
          send_item(random_entry());
        end else if (r < 4) begin
          q = random_entry();
          q.op   = 2'($urandom_range(0, 3));
          q.qlen = 8'($urandom);
          q.qmax = 8'($urandom);
          q.asn  = $urandom;
          send_item(q);
        end else if (r < 6 || roa_shadow.size() == 0) begin
          q = random_entry();
          q.op = $urandom_range(0, 1) ? OP_PREFIX : OP_ADDRESS;
          send_item(q);
        end else begin
          send_item(derived_query(roa_shadow[$urandom_range(0, roa_shadow.size() - 1)]));
        end
      end
    end
    calm = 1'b0;
    s_axis_tvalid_i <= 1'b0;

    // let the count of outstanding items settle past the last accept
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
